@@ src/lbts_pkg.sv @@
package lbts_pkg;

    localparam int MAX_TARGETS_DEF = 32;
    localparam int IDX_W           = 5;
    localparam int LOAD_W          = 32;
    localparam int CNT_W           = 6;
    localparam int RR_W            = 32;
    localparam int RULE_W          = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 6;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic FUNC_UPDATE  = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic [RULE_W-1:0] RULE_RR  = 2'd0;
    localparam logic [RULE_W-1:0] RULE_CPU = 2'd1;
    localparam logic [RULE_W-1:0] RULE_NET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_RULE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TARGETS = 2'd1;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_NONE   = 2'd1,
        CMD_RR     = 2'd2,
        CMD_LEAST  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic                      use_net;
        logic [CNT_W-1:0]          count;
        logic [IDX_W-1:0]          entry_index;
        logic signed [LOAD_W-1:0]  cpu_load;
        logic signed [LOAD_W-1:0]  network_load;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_wr_t;

    typedef struct packed {
        logic empty;
        cmd_t cmd;
    } q_rd_t;

endpackage

@@ src/lbts_front.sv @@
module lbts_front
    import lbts_pkg::*;
#(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_func,
    input  logic [IDX_W-1:0]         s_entry_index,
    input  logic signed [LOAD_W-1:0] s_cpu_load,
    input  logic signed [LOAD_W-1:0] s_network_load,
    input  logic                     q_full,
    output q_wr_t                    q_wr
);

    localparam int CLAMP       = (MAX_TARGETS < 63) ? MAX_TARGETS : 63;
    localparam int ENTRY_LIMIT = (MAX_TARGETS < 32) ? MAX_TARGETS : 32;

    logic [RULE_W-1:0]     select_rule_reg;
    logic [CNT_W-1:0]      active_targets_reg;
    logic [CNT_W-1:0]      count;
    logic                  in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_rule_reg    <= RULE_RR;
            active_targets_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SELECT_RULE: begin
                    // a rule code of 3 keeps the old rule
                    if (cfg_wdata[RULE_W-1:0] != 2'd3) begin
                        select_rule_reg <= cfg_wdata[RULE_W-1:0];
                    end
                end
                CFG_ACTIVE_TARGETS: begin
                    active_targets_reg <= cfg_wdata[CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign count    = (active_targets_reg > CNT_W'(CLAMP)) ? CNT_W'(CLAMP) : active_targets_reg;
    assign in_range = ({1'b0, s_entry_index} < CNT_W'(ENTRY_LIMIT));
    assign s_ready  = !q_full;

    always_comb begin
        q_wr.cmd.use_net      = (select_rule_reg == RULE_NET);
        q_wr.cmd.count        = count;
        q_wr.cmd.entry_index  = s_entry_index;
        q_wr.cmd.cpu_load     = s_cpu_load;
        q_wr.cmd.network_load = s_network_load;
        q_wr.push             = s_valid && !q_full;
        if (s_func == FUNC_UPDATE) begin
            q_wr.cmd.kind = CMD_UPDATE;
            // out-of-range updates are taken and dropped
            if (!in_range) begin
                q_wr.push = 1'b0;
            end
        end else if (count == '0) begin
            q_wr.cmd.kind = CMD_NONE;
        end else if (select_rule_reg == RULE_RR) begin
            q_wr.cmd.kind = CMD_RR;
        end else begin
            q_wr.cmd.kind = CMD_LEAST;
        end
    end

endmodule

@@ src/lbts_queue.sv @@
module lbts_queue
    import lbts_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  q_wr_t q_wr,
    output logic  q_full,
    input  logic  q_pop,
    output q_rd_t q_rd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t                 slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       fill_reg;
    logic                 do_push;
    logic                 do_pop;

    assign q_full     = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_rd.empty = (fill_reg == '0);
    assign q_rd.cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = q_wr.push && !q_full;
    assign do_pop     = q_pop && !q_rd.empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= q_wr.cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/lbts_back.sv @@
module lbts_back
    import lbts_pkg::*;
#(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  q_rd_t            q_rd,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [IDX_W-1:0] m_target_index,
    output logic             m_found
);

    localparam int AW     = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int STEP_W = $clog2(RR_W);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [RR_W-1:0]          rr_counter_reg, rr_counter_next;
    logic [RR_W-1:0]          div_num_reg, div_num_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [CNT_W-1:0]         issue_idx_reg, issue_idx_next;
    logic [CNT_W-1:0]         data_idx_reg, data_idx_next;
    logic                     first_reg, first_next;
    logic signed [LOAD_W-1:0] best_val_reg, best_val_next;
    logic [CNT_W-1:0]         best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]         res_idx_reg, res_idx_next;
    logic                     res_found_reg, res_found_next;
    logic                     m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]         m_target_index_reg, m_target_index_next;
    logic                     m_found_reg, m_found_next;

    logic signed [LOAD_W-1:0] cpu_mem [MAX_TARGETS];
    logic signed [LOAD_W-1:0] net_mem [MAX_TARGETS];
    logic [MAX_TARGETS-1:0]   entry_valid_reg;
    logic signed [LOAD_W-1:0] rd_cpu_reg;
    logic signed [LOAD_W-1:0] rd_net_reg;
    logic                     rd_vld_reg;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic                     out_free;
    logic [CNT_W:0]           trial;
    logic [CNT_W-1:0]         rem_step;
    logic signed [LOAD_W-1:0] cur_val;
    logic                     take_cur;
    logic [CNT_W-1:0]         sel_idx;

    assign out_free = !m_valid_reg || m_ready;
    assign wr_addr  = AW'(q_rd.cmd.entry_index);

    // one restoring step of rr_counter mod count
    assign trial    = {rem_reg, div_num_reg[RR_W-1]};
    assign rem_step = (trial >= {1'b0, cmd_reg.count}) ?
                      CNT_W'(trial - {1'b0, cmd_reg.count}) : CNT_W'(trial);

    // entries never written read as zero
    always_comb begin
        if (!rd_vld_reg) begin
            cur_val = '0;
        end else if (cmd_reg.use_net) begin
            cur_val = rd_net_reg;
        end else begin
            cur_val = rd_cpu_reg;
        end
    end
    assign take_cur = first_reg || (cur_val < best_val_reg);
    assign sel_idx  = take_cur ? data_idx_reg : best_idx_reg;

    always_comb begin
        state_next          = state_reg;
        cmd_next            = cmd_reg;
        rr_counter_next     = rr_counter_reg;
        div_num_next        = div_num_reg;
        rem_next            = rem_reg;
        step_next           = step_reg;
        issue_idx_next      = issue_idx_reg;
        data_idx_next       = data_idx_reg;
        first_next          = first_reg;
        best_val_next       = best_val_reg;
        best_idx_next       = best_idx_reg;
        res_idx_next        = res_idx_reg;
        res_found_next      = res_found_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_target_index_next = m_target_index_reg;
        m_found_next        = m_found_reg;
        q_pop               = 1'b0;
        wr_en               = 1'b0;
        rd_addr             = AW'(issue_idx_reg);

        case (state_reg)
            ST_IDLE: begin
                if (!q_rd.empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_rd.cmd;
                    case (q_rd.cmd.kind)
                        CMD_UPDATE: begin
                            wr_en = 1'b1;
                        end
                        CMD_NONE: begin
                            res_idx_next   = '0;
                            res_found_next = 1'b0;
                            state_next     = ST_DONE;
                        end
                        CMD_RR: begin
                            div_num_next    = rr_counter_reg;
                            rr_counter_next = rr_counter_reg + 1'b1;
                            rem_next        = '0;
                            step_next       = '0;
                            state_next      = ST_DIV;
                        end
                        CMD_LEAST: begin
                            rd_addr        = '0;
                            issue_idx_next = CNT_W'(1);
                            data_idx_next  = '0;
                            first_next     = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                rem_next     = rem_step;
                div_num_next = div_num_reg << 1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(RR_W-1)) begin
                    res_idx_next   = IDX_W'(rem_step);
                    res_found_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_SCAN: begin
                first_next     = 1'b0;
                issue_idx_next = issue_idx_reg + 1'b1;
                data_idx_next  = data_idx_reg + 1'b1;
                if (take_cur) begin
                    best_val_next = cur_val;
                    best_idx_next = data_idx_reg;
                end
                if (data_idx_reg == CNT_W'(cmd_reg.count - 1'b1)) begin
                    res_idx_next   = IDX_W'(sel_idx);
                    res_found_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_target_index_next = res_idx_reg;
                    m_found_next        = res_found_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // load table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cpu_mem[wr_addr] <= q_rd.cmd.cpu_load;
            net_mem[wr_addr] <= q_rd.cmd.network_load;
        end
        rd_cpu_reg <= cpu_mem[rd_addr];
        rd_net_reg <= net_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            rd_vld_reg      <= 1'b0;
        end else begin
            if (wr_en) begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= entry_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rr_counter_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rr_counter_reg <= rr_counter_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg            <= cmd_next;
        div_num_reg        <= div_num_next;
        rem_reg            <= rem_next;
        step_reg           <= step_next;
        issue_idx_reg      <= issue_idx_next;
        data_idx_reg       <= data_idx_next;
        first_reg          <= first_next;
        best_val_reg       <= best_val_next;
        best_idx_reg       <= best_idx_next;
        res_idx_reg        <= res_idx_next;
        res_found_reg      <= res_found_next;
        m_target_index_reg <= m_target_index_next;
        m_found_reg        <= m_found_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_target_index = m_target_index_reg;
    assign m_found        = m_found_reg;

endmodule

@@ src/load_balance_target_select.sv @@
// timing: an update is written to the table when the back end pops it from the queue;
// a round-robin request takes 32 one-bit remainder steps; a least-load request
// scans min(active_targets, 32) entries (one table entry read per cycle, registered read);
// a request with no active target is answered without a search
// throughput: one request at a time in the back end, updates are written from the idle state;
// a two-entry queue keeps accepting items while a request is worked on, until it is full
// reset: synchronous active-low aresetn clears config, counter, queue and table valid bits
module load_balance_target_select
    import lbts_pkg::*;
#(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_func,
    input  logic [IDX_W-1:0]         s_entry_index,
    input  logic signed [LOAD_W-1:0] s_cpu_load,
    input  logic signed [LOAD_W-1:0] s_network_load,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [IDX_W-1:0]         m_target_index,
    output logic                     m_found
);

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    lbts_front #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_entry_index  (s_entry_index),
        .s_cpu_load     (s_cpu_load),
        .s_network_load (s_network_load),
        .q_full         (q_full),
        .q_wr           (q_wr)
    );

    lbts_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_rd    (q_rd)
    );

    lbts_back #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_rd           (q_rd),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_target_index (m_target_index),
        .m_found        (m_found)
    );

endmodule
